// ----- hdl/pcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared constants and types for the percentile color balance unit.
// ----------------------------------------------------------------------------
package pcb_pkg;
  localparam int unsigned MaxPixelsDefault = 2097152;
  localparam int unsigned ClipFull = 20000;
  localparam int unsigned ClipMax = 10000;
  localparam int ClipW = 14;
  localparam int BinW = 22;
  localparam int CountW = 25;
  localparam int RankW = 25;

  localparam logic [1:0] CfgBlue = 2'd0;
  localparam logic [1:0] CfgGreen = 2'd1;
  localparam logic [1:0] CfgRed = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_GATHER = 8'b00000010,
    ST_RANK   = 8'b00000100,
    ST_WALK   = 8'b00001000,
    ST_WALKW  = 8'b00010000,
    ST_CLEAR  = 8'b00100000,
    ST_MAP    = 8'b01000000,
    ST_INIT   = 8'b10000000
  } state_t;

  typedef struct packed {
    logic hist_inc;
    logic count_clr;
    logic rank_start;
    logic walk_start;
    logic walk_step;
    logic clear_step;
    logic map_start;
    logic map_step;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic walk_done;
    logic clear_done;
    logic map_done;
  } status_t;
endpackage

// ----- hdl/percentile_color_balance_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percentile_color_balance_unit
// Per-channel percentile stretch of a blue-green-red frame in two passes.
// ----------------------------------------------------------------------------
// A pixel transfer happens when start is high and busy is low. func low
// feeds the histograms (no result); func high maps the pixel. A mapped
// result appears on blue_out, green_out, red_out and frame_end for one
// cycle with done high; the receiver cannot stall. Gather and map pixels
// hold busy high, for the histogram read-modify-write and for the 16-step
// serial divider of the stretch. The last gather pixel starts a 256-step
// histogram walk that compares scaled running counts against the rank
// products, then a clear of all 256 histogram bins, before the next
// transfer (only the clear for a frame with no counted pixel). After reset
// the histograms are swept clear while busy is high. The user must write
// the clip registers through cfg_we, cfg_index and cfg_data only while no
// frame is in flight; the block does not enforce it. They take effect at
// the next last gather pixel.
// ----------------------------------------------------------------------------
module percentile_color_balance_unit import pcb_pkg::*; #(
  parameter int unsigned MaxPixels = MaxPixelsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  logic [7:0]       blue,
  input  logic [7:0]       green,
  input  logic [7:0]       red,
  input  logic             last_pixel,
  output logic             done,
  output logic [7:0]       blue_out,
  output logic [7:0]       green_out,
  output logic [7:0]       red_out,
  output logic             frame_end,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [ClipW-1:0] cfg_data
);
  logic [ClipW-1:0] clip [3];
  cmd_t    cmd;
  status_t sts;
  logic [7:0] pix [3];
  logic [7:0] pout [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) clip[c] <= ClipW'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgBlue:  clip[0] <= cfg_data;
        CfgGreen: clip[1] <= cfg_data;
        CfgRed:   clip[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix[0] = blue;
  assign pix[1] = green;
  assign pix[2] = red;

  pcb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func), .last_pixel(last_pixel),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  pcb_datapath #(.MaxPixels(MaxPixels)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .clip(clip), .pix(pix),
    .last_in(last_pixel), .pout(pout), .frame_end(frame_end)
  );

  assign blue_out = pout[0];
  assign green_out = pout[1];
  assign red_out = pout[2];
endmodule

// ----- hdl/pcb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/pcb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_datapath
// Histograms, rank arithmetic, level walk and stretch divider.
// ----------------------------------------------------------------------------
module pcb_datapath import pcb_pkg::*; #(
  parameter int unsigned MaxPixels = MaxPixelsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          sts,
  input  logic [ClipW-1:0] clip [3],
  input  logic [7:0]       pix [3],
  input  logic             last_in,
  output logic [7:0]       pout [3],
  output logic             frame_end
);
  localparam int ProdW = RankW + 15;

  // histogram rams, read-modify-write with registered read data
  logic [7:0]      raddr [3];
  logic [7:0]      waddr [3];
  logic            we [3];
  logic [BinW-1:0] wdata [3];
  logic [BinW-1:0] rdata [3];
  logic            inc_d;
  logic [7:0]      pix_d [3];
  logic [7:0]      clr_addr;
  logic [7:0]      walk_addr;
  logic [CountW-1:0] count;

  for (genvar c = 0; c < 3; c++) begin : g_hist
    pcb_ram #(.Width(BinW), .Depth(256)) u_ram (
      .clk(clk), .we(we[c]), .waddr(waddr[c]), .wdata(wdata[c]),
      .raddr(raddr[c]), .rdata(rdata[c])
    );
    always_comb begin
      raddr[c] = cmd.hist_inc ? pix[c] : walk_addr;
      we[c] = inc_d | cmd.clear_step;
      waddr[c] = inc_d ? pix_d[c] : clr_addr;
      wdata[c] = inc_d ? rdata[c] + BinW'(1) : '0;
    end
  end

  // forwarding for back-to-back increments of the same bin is avoided by
  // the controller holding busy high in ST_GATHER after each gather transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      inc_d <= 1'b0;
      count <= '0;
      clr_addr <= '0;
    end else begin
      inc_d <= cmd.hist_inc && (count < CountW'(MaxPixels));
      if (cmd.hist_inc && (count < CountW'(MaxPixels))) begin
        count <= count + CountW'(1);
      end else if (cmd.count_clr) begin
        count <= '0;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 8'd1;
      end
    end
    pix_d <= pix;
  end

  assign sts.clear_done = (clr_addr == 8'd255);
  assign sts.count_zero = (count == '0);

  // rank products: low side n*clip, high side n*(full-clip)+full
  logic [ClipW-1:0] clipsat [3];
  logic [ProdW-1:0] prod_lo [3];
  logic [ProdW-1:0] prod_hi [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      clipsat[c] = (clip[c] > ClipW'(ClipMax)) ? ClipW'(ClipMax) : clip[c];
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.rank_start) begin
      for (int c = 0; c < 3; c++) begin
        prod_lo[c] <= ProdW'(count) * ProdW'(clipsat[c]);
        prod_hi[c] <= ProdW'(count) * ProdW'(ClipFull - 32'(clipsat[c]))
                      + ProdW'(ClipFull);
      end
    end
  end

  // walk: running count scaled by full compared against rank products,
  // high level also stops at the last counted pixel
  logic [RankW-1:0] cum [3];
  logic [7:0]       lo_lv [3];
  logic [7:0]       hi_lv [3];
  logic             lo_found [3];
  logic             hi_found [3];
  logic [7:0]       vidx;
  logic             walk_act;
  logic [RankW-1:0] cum_next [3];
  logic [ProdW-1:0] cum_scaled [3];
  logic             lo_hit [3];
  logic             hi_hit [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cum_next[c] = cum[c] + RankW'(rdata[c]);
      cum_scaled[c] = ProdW'(cum_next[c]) * ProdW'(ClipFull);
      lo_hit[c] = (cum_scaled[c] > prod_lo[c]);
      hi_hit[c] = (cum_scaled[c] >= prod_hi[c]) || (cum_next[c] >= RankW'(count));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_addr <= '0;
      walk_act <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        lo_lv[c] <= 8'd0;
        hi_lv[c] <= 8'd255;
      end
    end else begin
      if (cmd.walk_start) begin
        walk_addr <= 8'd0;
        vidx <= 8'd0;
        walk_act <= 1'b1;
        for (int c = 0; c < 3; c++) begin
          cum[c] <= '0;
          lo_found[c] <= 1'b0;
          hi_found[c] <= 1'b0;
          lo_lv[c] <= 8'd255;
          hi_lv[c] <= 8'd255;
        end
      end else if (walk_act) begin
        walk_addr <= walk_addr + 8'd1;
        if (cmd.walk_step) begin
          vidx <= vidx + 8'd1;
          if (vidx == 8'd255) begin
            walk_act <= 1'b0;
          end
          for (int c = 0; c < 3; c++) begin
            cum[c] <= cum_next[c];
            if (!lo_found[c] && lo_hit[c]) begin
              lo_found[c] <= 1'b1;
              lo_lv[c] <= vidx;
            end
            if (!hi_found[c] && hi_hit[c]) begin
              hi_found[c] <= 1'b1;
              hi_lv[c] <= vidx;
            end
          end
        end
      end
    end
  end
  assign sts.walk_done = !walk_act;

  // stretch: num = (x-lo)*255, restoring division by d, 3 lanes
  logic [15:0] snum [3];
  logic [15:0] squo [3];
  logic [8:0]  srem [3];
  logic [7:0]  sd [3];
  logic [4:0]  scnt;
  logic        slast;
  logic [7:0]  xc [3];
  logic [9:0]  strial [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      xc[c] = (pix[c] < lo_lv[c]) ? lo_lv[c] : pix[c];
      xc[c] = (xc[c] > hi_lv[c]) ? hi_lv[c] : xc[c];
      strial[c] = {srem[c], snum[c][15]};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
    end else if (cmd.map_start) begin
      scnt <= 5'd16;
      slast <= last_in;
      for (int c = 0; c < 3; c++) begin
        sd[c] <= (hi_lv[c] > lo_lv[c]) ? hi_lv[c] - lo_lv[c] : 8'd0;
        snum[c] <= 16'(xc[c] - lo_lv[c]) * 16'd255;
        srem[c] <= '0;
      end
    end else if (cmd.map_step && scnt != 0) begin
      scnt <= scnt - 5'd1;
      for (int c = 0; c < 3; c++) begin
        snum[c] <= snum[c] << 1;
        if (strial[c] >= {2'b0, sd[c]}) begin
          srem[c] <= 9'(strial[c] - {2'b0, sd[c]});
          squo[c] <= {squo[c][14:0], 1'b1};
        end else begin
          srem[c] <= strial[c][8:0];
          squo[c] <= {squo[c][14:0], 1'b0};
        end
      end
    end
  end
  assign sts.map_done = (scnt == 0);

  logic [16:0] qr [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qr[c] = {1'b0, squo[c]};
      if ({srem[c], 1'b0} > {2'b0, sd[c]} ||
          ({srem[c], 1'b0} == {2'b0, sd[c]} && squo[c][0])) begin
        qr[c] = qr[c] + 17'd1;
      end
      if (sd[c] == 8'd0) begin
        pout[c] = 8'd0;
      end else begin
        pout[c] = (qr[c] > 17'd255) ? 8'd255 : qr[c][7:0];
      end
    end
  end
  assign frame_end = slast;
endmodule

// ----- hdl/pcb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_ctrl
// Sequencer for gather, level walk, histogram clear and map passes.
// ----------------------------------------------------------------------------
module pcb_ctrl import pcb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    func,
  input  logic    last_pixel,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);
  state_t state, state_next;
  logic   last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (start && !busy) begin
        last_q <= last_pixel;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (func) begin
            cmd.map_start = 1'b1;
            state_next = ST_MAP;
          end else begin
            cmd.hist_inc = 1'b1;
            state_next = ST_GATHER;
          end
        end
      end
      ST_GATHER: begin
        if (!last_q) state_next = ST_IDLE;
        else if (sts.count_zero) state_next = ST_CLEAR;
        else begin
          cmd.rank_start = 1'b1;
          state_next = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.walk_start = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        state_next = ST_WALKW;
      end
      ST_WALKW: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          cmd.count_clr = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MAP: begin
        cmd.map_step = 1'b1;
        if (sts.map_done) begin
          cmd.map_step = 1'b0;
          done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- tb/percentile_color_balance_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percentile_color_balance_unit_tb
// Self-checking bench for the percentile color balance unit. Frames are sent
// as a gather pass followed by a map pass; an internal predictor keeps its
// own histograms and levels and checks every mapped pixel in order. Clip
// registers are swept through several settings, extremes included.
// ----------------------------------------------------------------------------
module percentile_color_balance_unit_tb;
  import pcb_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles = 600;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       fe;
  } pix_res_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             func;
  logic [7:0]       blue;
  logic [7:0]       green;
  logic [7:0]       red;
  logic             last_pixel;
  logic             done;
  logic [7:0]       blue_out;
  logic [7:0]       green_out;
  logic [7:0]       red_out;
  logic             frame_end;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [ClipW-1:0] cfg_data;

  int unsigned hist_bins [3][256];
  int unsigned gathered;
  logic [7:0]  lvl_lo [3];
  logic [7:0]  lvl_hi [3];
  logic [ClipW-1:0] clip_set [3];
  pix_res_t    balanced_q [$];
  int          err_count;
  int          idle_cycles;

  percentile_color_balance_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .blue(blue), .green(green), .red(red), .last_pixel(last_pixel),
    .done(done), .blue_out(blue_out), .green_out(green_out),
    .red_out(red_out), .frame_end(frame_end), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] level_at(int ch, longint unsigned rank);
    longint unsigned cum;
    cum = 0;
    for (int v = 0; v < 256; v++) begin
      cum += hist_bins[ch][v];
      if (cum > rank) return v[7:0];
    end
    return 8'd255;
  endfunction

  function automatic logic [7:0] stretch_px(logic [7:0] x, logic [7:0] lo, logic [7:0] hi);
    int unsigned xv, d, num, q, rm;
    xv = x;
    if (xv < lo) xv = lo;
    if (xv > hi) xv = hi;
    if (hi <= lo) return 8'd0;
    d = hi - lo;
    num = (xv - lo) * 255;
    q = num / d;
    rm = num % d;
    if (2 * rm > d || (2 * rm == d && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  task automatic predict_pixel(logic f, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                               logic lp);
    logic [7:0] s [3];
    longint unsigned n, clip, lo_rank, hi_rank;
    pix_res_t res;
    s[0] = b; s[1] = g; s[2] = r;
    if (!f) begin
      if (gathered < MaxPixelsDefault) begin
        for (int c = 0; c < 3; c++) hist_bins[c][s[c]]++;
        gathered++;
      end
      if (lp) begin
        n = gathered;
        if (n != 0) begin
          for (int c = 0; c < 3; c++) begin
            clip = (clip_set[c] > ClipMax) ? ClipMax : clip_set[c];
            lo_rank = (n * clip) / ClipFull;
            hi_rank = (n * (ClipFull - clip) + ClipFull - 1) / ClipFull;
            if (hi_rank > n - 1) hi_rank = n - 1;
            lvl_lo[c] = level_at(c, lo_rank);
            lvl_hi[c] = level_at(c, hi_rank);
          end
        end
        for (int c = 0; c < 3; c++)
          for (int v = 0; v < 256; v++) hist_bins[c][v] = 0;
        gathered = 0;
      end
    end else begin
      res.b = stretch_px(b, lvl_lo[0], lvl_hi[0]);
      res.g = stretch_px(g, lvl_lo[1], lvl_hi[1]);
      res.r = stretch_px(r, lvl_lo[2], lvl_hi[2]);
      res.fe = lp;
      balanced_q.push_back(res);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    pix_res_t want;
    if (!rst && done) begin
      if (balanced_q.size() == 0) begin
        $display("unexpected result transfer");
        err_count++;
      end else begin
        want = balanced_q.pop_front();
        if (blue_out !== want.b) report_mismatch("blue_out", blue_out, want.b);
        if (green_out !== want.g) report_mismatch("green_out", green_out, want.g);
        if (red_out !== want.r) report_mismatch("red_out", red_out, want.r);
        if (frame_end !== want.fe) report_mismatch("frame_end", frame_end, want.fe);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  int burst_left;

  task automatic send_pixel(logic f, logic [7:0] b, logic [7:0] g, logic [7:0] r, logic lp);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    burst_left--;
    start <= 1'b1; func <= f; blue <= b; green <= g; red <= r; last_pixel <= lp;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pixel(f, b, g, r, lp);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (balanced_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_clip(logic [1:0] idx, logic [ClipW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    clip_set[idx] = val;
  endtask

  task automatic set_clips(logic [ClipW-1:0] cb, logic [ClipW-1:0] cg, logic [ClipW-1:0] cr);
    drain_results();
    write_clip(CfgBlue, cb);
    write_clip(CfgGreen, cg);
    write_clip(CfgRed, cr);
  endtask

  // gather pass of n random pixels, then map pass of m random pixels
  task automatic run_frame(int n, int m, int spread);
    int lo;
    lo = $urandom_range(0, 255 - spread);
    for (int i = 0; i < n; i++)
      send_pixel(1'b0, lo + $urandom_range(0, spread), lo + $urandom_range(0, spread),
                 lo + $urandom_range(0, spread), i == n - 1);
    for (int i = 0; i < m; i++)
      send_pixel(1'b1, $urandom, $urandom, $urandom, i == m - 1);
  endtask

  task automatic test_directed();
    // map before any frame: default levels
    send_pixel(1'b1, 8'd0, 8'd255, 8'd128, 1'b0);
    send_pixel(1'b1, 8'd255, 8'd0, 8'd1, 1'b1);
    // single-pixel frame: lone last pixel sets both levels to 0
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0, 1'b1);
    // flat channel plus extremes
    send_pixel(1'b0, 8'd7, 8'd0, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd7, 8'd255, 8'd0, 1'b0);
    send_pixel(1'b0, 8'd7, 8'd128, 8'd100, 1'b1);
    send_pixel(1'b1, 8'd7, 8'd0, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(1'b1, 8'd255, 8'd64, 8'd50, 1'b1);
    // tie rounding: levels 0 and 2
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(1'b0, 8'd2, 8'd2, 8'd2, 1'b1);
    send_pixel(1'b1, 8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(1'b1, 8'd3, 8'd2, 8'd0, 1'b1);
  endtask

  task automatic test_clip_extremes();
    set_clips(14'd0, 14'd10000, 14'd16383);
    run_frame(20, 10, 255);
    set_clips(14'd9999, 14'd1, 14'd5000);
    run_frame(15, 10, 200);
  endtask

  task automatic test_random_frames();
    int fr;
    fr = 0;
    while (fr < 55) begin
      if (fr % 8 == 0)
        set_clips($urandom_range(0, 16383), $urandom_range(0, 2000), $urandom_range(0, 10000));
      if (fr == 20) drain_results();
      if ($urandom_range(0, 9) == 0)
        send_pixel($urandom, $urandom, $urandom, $urandom, $urandom);
      else
        run_frame($urandom_range(1, 25), $urandom_range(1, 20), $urandom_range(0, 255));
      fr++;
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; func = 1'b0; blue = '0; green = '0; red = '0;
    last_pixel = 1'b0; cfg_we = 1'b0; cfg_index = CfgBlue; cfg_data = '0;
    err_count = 0; gathered = 0; burst_left = 0; idle_cycles = 0;
    for (int c = 0; c < 3; c++) begin
      lvl_lo[c] = 8'd0; lvl_hi[c] = 8'd255; clip_set[c] = 14'd100;
      for (int v = 0; v < 256; v++) hist_bins[c][v] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_clip_extremes();
    test_random_frames();
    set_clips(14'd100, 14'd100, 14'd100);
    run_frame(200, 150, 255);
    drain_results();
    if (err_count == 0 && balanced_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
